[rtl/rfp_pkg.sv]
// Shared types, relocation codes and field masks for the relocation field patcher.
`default_nettype none

package rfp_pkg;

    // Relocation type codes as carried in the mode field
    typedef enum logic [3:0] {
        MODE_REL8    = 4'd0,
        MODE_REL16   = 4'd1,
        MODE_REL32   = 4'd2,
        MODE_REL24W  = 4'd3,
        MODE_REL11T  = 4'd4,
        MODE_REL22T  = 4'd5,
        MODE_REL8T   = 4'd6,
        MODE_REL16TB = 4'd7,
        MODE_ABS8    = 4'd8,
        MODE_ABS16   = 4'd9,
        MODE_ABS32   = 4'd10,
        MODE_ABS64   = 4'd11
    } reloc_mode_t;

    // How the last stage builds the patched word
    typedef enum logic [1:0] {
        OP_ADD_MASK = 2'd0,
        OP_SPLIT22  = 2'd1,
        OP_SPLIT16  = 2'd2
    } patch_op_t;

    localparam logic [63:0] FIELD8_MASK  = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] FIELD11_MASK = 64'h0000_0000_0000_07FF;
    localparam logic [63:0] FIELD16_MASK = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] FIELD24_MASK = 64'h0000_0000_00FF_FFFF;
    localparam logic [63:0] FIELD32_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] FIELD64_MASK = 64'hFFFF_FFFF_FFFF_FFFF;

    // Input transaction
    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] site_address;
        logic [63:0] target_address;
        logic [63:0] site_word;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [63:0] patched_word;
        logic        bad_type;
    } result_t;

    // Stage 1 to stage 2: difference taken
    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] target;
        logic [63:0] word;
        logic [31:0] diff;
    } s1_t;

    // Stage 2 to stage 3: addend and field selected
    typedef struct packed {
        patch_op_t   op;
        logic        bad;
        logic [63:0] word;
        logic [63:0] mask;
        logic [63:0] addend;
    } s2_t;

endpackage

`default_nettype wire

[rtl/rfp_diff.sv]
// Stage 1: 32-bit distance from site to target.
`default_nettype none

module rfp_diff
    import rfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output logic       valid_reg,
    output s1_t        data_reg
);

    s1_t data_next;

    // Difference modulo 2^32 only needs the low halves
    always_comb
    begin
        data_next.mode   = in_item.mode;
        data_next.target = in_item.target_address;
        data_next.word   = in_item.site_word;
        data_next.diff   = in_item.target_address[31:0] - in_item.site_address[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

[rtl/rfp_offset.sv]
// Stage 2: decode the relocation type into field mask, addend and patch form.
`default_nettype none

module rfp_offset
    import rfp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire s1_t  in_data,
    output logic      valid_reg,
    output s2_t       data_reg
);

    s2_t         data_next;
    logic [31:0] dm1;
    logic [31:0] dm2;
    logic [31:0] dm4;
    logic [31:0] dm8;
    logic [31:0] half_off;
    logic [31:0] word_off;

    // Pipe-relative distances and their scaled forms (arithmetic shifts)
    assign dm1      = in_data.diff - 32'd1;
    assign dm2      = in_data.diff - 32'd2;
    assign dm4      = in_data.diff - 32'd4;
    assign dm8      = in_data.diff - 32'd8;
    assign half_off = {dm4[31], dm4[31:1]};
    assign word_off = {{2{dm8[31]}}, dm8[31:2]};

    always_comb
    begin
        data_next.op     = OP_ADD_MASK;
        data_next.bad    = 1'b0;
        data_next.word   = in_data.word;
        data_next.mask   = '0;
        data_next.addend = '0;
        case (in_data.mode)
            MODE_REL8:
            begin
                data_next.mask   = FIELD8_MASK;
                data_next.addend = {32'd0, dm1};
            end
            MODE_REL16:
            begin
                data_next.mask   = FIELD16_MASK;
                data_next.addend = {32'd0, dm2};
            end
            MODE_REL32:
            begin
                data_next.mask   = FIELD32_MASK;
                data_next.addend = {32'd0, dm4};
            end
            MODE_REL24W:
            begin
                data_next.mask   = FIELD24_MASK;
                data_next.addend = {32'd0, word_off};
            end
            MODE_REL11T:
            begin
                data_next.mask   = FIELD11_MASK;
                data_next.addend = {32'd0, half_off};
            end
            MODE_REL22T:
            begin
                data_next.op     = OP_SPLIT22;
                data_next.addend = {32'd0, half_off};
            end
            MODE_REL8T:
            begin
                data_next.mask   = FIELD8_MASK;
                data_next.addend = {32'd0, half_off};
            end
            MODE_REL16TB:
            begin
                data_next.op     = OP_SPLIT16;
                data_next.addend = {32'd0, dm8};
            end
            MODE_ABS8:
            begin
                data_next.mask   = FIELD8_MASK;
                data_next.addend = in_data.target;
            end
            MODE_ABS16:
            begin
                data_next.mask   = FIELD16_MASK;
                data_next.addend = in_data.target;
            end
            MODE_ABS32:
            begin
                data_next.mask   = FIELD32_MASK;
                data_next.addend = in_data.target;
            end
            MODE_ABS64:
            begin
                data_next.mask   = FIELD64_MASK;
                data_next.addend = in_data.target;
            end
            default:
            begin
                // unknown type: empty mask leaves the word as it is
                data_next.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

[rtl/rfp_merge.sv]
// Stage 3: add into the field, merge with untouched bits, hold the result.
`default_nettype none

module rfp_merge
    import rfp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire s2_t  in_data,
    output logic      valid_reg,
    output result_t   data_reg
);

    result_t     data_next;
    logic [63:0] sum;
    logic [63:0] add_word;
    logic [21:0] v22;
    logic [15:0] v16;
    logic [63:0] split22_word;
    logic [63:0] split16_word;

    // Masked field add
    assign sum      = in_data.word + in_data.addend;
    assign add_word = (in_data.word & ~in_data.mask) | (sum & in_data.mask);

    // Thumb long branch: 22-bit value spread over both halfwords
    assign v22 = {in_data.word[10:0], in_data.word[26:16]} + in_data.addend[21:0];
    assign split22_word = {in_data.word[63:32],
                           in_data.word[31:27], v22[10:0],
                           in_data.word[15:11], v22[21:11]};

    // Split 16-bit branch: value written, not added; top bit of H1 cleared
    assign v16 = in_data.addend[15:0];
    assign split16_word = {in_data.word[63:32],
                           1'b0, v16[10:8], in_data.word[27:24], v16[7:0],
                           in_data.word[15:11], v16[11], in_data.word[9:4], v16[15:12]};

    always_comb
    begin
        data_next.bad_type = in_data.bad;
        case (in_data.op)
            OP_ADD_MASK: data_next.patched_word = add_word;
            OP_SPLIT22:  data_next.patched_word = split22_word;
            OP_SPLIT16:  data_next.patched_word = split16_word;
            default:     data_next.patched_word = in_data.word;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

[rtl/relocation_field_patcher_top.sv]
// Top level of the relocation field patcher: three-stage pipeline.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    item   (item_t)
//  result    out        result_valid / result_stall result (result_t)
//
// One transaction per cycle sustained while result_stall stays low; a result
// passes the difference, decode/offset and add/merge stages to result_valid.
// The last stage register is the output register.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall holds the result and the full stages directly behind it; empty
// stages keep filling, so item_stall rises only when all three are full.
`default_nettype none

module relocation_field_patcher_top
    import rfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic s1_valid;
    logic s2_valid;
    s1_t  s1_data;
    s2_t  s2_data;
    logic en1;
    logic en2;
    logic en3;

    // Stage enables: a stage loads when it is empty or its contents move on
    assign en3        = !result_valid || !result_stall;
    assign en2        = !s2_valid || en3;
    assign en1        = !s1_valid || en2;
    assign item_stall = !en1;

    rfp_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .in_valid  (item_valid),
        .in_item   (item),
        .valid_reg (s1_valid),
        .data_reg  (s1_data)
    );

    rfp_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .valid_reg (s2_valid),
        .data_reg  (s2_data)
    );

    rfp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .valid_reg (result_valid),
        .data_reg  (result)
    );

endmodule

`default_nettype wire

[rtl/rfp_checker.sv]
// Port-level assertions for the relocation field patcher, bound to the top level.
`default_nettype none

module rfp_checker
    import rfp_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    logic item_acc;
    logic item_unknown;
    logic item_abs64;

    assign item_acc     = item_valid && !item_stall;
    assign item_unknown = item.mode > 4'(MODE_ABS64);
    assign item_abs64   = item.mode == 4'(MODE_ABS64);

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Unknown type passes through flagged when the result is not stalled
    a_unknown_pass: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && item_unknown ##1 !result_stall ##1 !result_stall
        |=> result_valid && result.bad_type
            && result.patched_word == $past(item.site_word, 3))
        else $error("unknown type not passed through");

    // Full-width absolute add
    a_abs64_sum: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && item_abs64 ##1 !result_stall ##1 !result_stall
        |=> result_valid && !result.bad_type
            && result.patched_word
               == $past(item.site_word, 3) + $past(item.target_address, 3))
        else $error("abs64 result wrong");

    // The pipeline never backs up while the output is empty
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty output");

    // Reset sampled low at a clock edge leaves no valid result
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid in reset");

endmodule

bind relocation_field_patcher_top rfp_checker u_rfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
